/* hw/rtl/cagp_pkg.sv */
// cagp_pkg: shared constants and types of the cave automaton generation pass
// used by cagp_cell, cagp_out_fifo and cave_automaton_generation_pass_unit
// no dependencies
package cagp_pkg;

  // default limits for the top-level parameters
  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int MIN_SIZE       = 5;

  // register reset values
  localparam logic [4:0]  NEAR_CUTOFF_RST = 5'd30;
  localparam logic [4:0]  FAR_CUTOFF_RST  = 5'd5;
  localparam logic [9:0]  GRID_WIDTH_RST  = 10'd300;
  localparam logic [10:0] GRID_HEIGHT_RST = 11'd200;

  // register map, by word index
  typedef enum logic [1:0] {
    REG_NEAR_CUTOFF,
    REG_FAR_CUTOFF,
    REG_GRID_WIDTH,
    REG_GRID_HEIGHT
  } cagp_reg_t;

  // cell codes and input modes
  localparam logic [1:0] CODE_GRAVEL = 2'd0;
  localparam logic [1:0] CODE_WALL   = 2'd1;
  localparam logic       MODE_FLUSH  = 1'b1;

  // window geometry: five columns of five 2-bit cells
  localparam int WIN_COLS = 5;
  localparam int WIN_ROWS = 5;
  localparam int COL_BITS = 2 * WIN_ROWS;
  localparam int LINE_BITS = COL_BITS - 2;

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  typedef struct packed {
    logic [3:0] near_cnt;
    logic [4:0] far_cnt;
  } cagp_cnt_t;

  typedef struct packed {
    logic [1:0] new_cell;
    logic       last_of_frame;
  } cagp_res_t;

endpackage

/* hw/rtl/cagp_ram.sv */
// cagp_ram: generic simple dual-port ram, one write and one registered read port
// read returns the old contents on a same-address write
// no dependencies
module cagp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/cagp_cell.sv */
// cagp_cell: one column of the 5x5 window; shifts its column to the next cell
// and adds its near/far non-gravel counts onto the running chain sum
// depends on cagp_pkg
module cagp_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          shift_en,
  input  logic [cagp_pkg::COL_BITS-1:0] col_in,
  output logic [cagp_pkg::COL_BITS-1:0] col_q,
  input  logic                          col_ok,
  input  logic                          outer,
  input  logic [cagp_pkg::WIN_ROWS-1:0] row_ok,
  input  cagp_pkg::cagp_cnt_t           cnt_in,
  output cagp_pkg::cagp_cnt_t           cnt_out
);
  import cagp_pkg::*;

  logic [COL_BITS-1:0] col_r;
  logic [WIN_ROWS-1:0] occ;
  logic [WIN_ROWS-1:0] far_sel;
  logic [WIN_ROWS-1:0] near_sel;
  logic [1:0]          near_mine;
  logic [2:0]          far_mine;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift_en) begin
      col_r <= col_in;
    end
  end

  always_comb begin
    for (int p = 0; p < WIN_ROWS; p++) begin
      occ[p] = (col_r[2*p +: 2] != CODE_GRAVEL) && row_ok[p] && col_ok;
      // outer columns drop the window corners and take no part in the 3x3
      far_sel[p]  = !(outer && (p == 0 || p == WIN_ROWS - 1));
      near_sel[p] = !outer && p != 0 && p != WIN_ROWS - 1;
    end
    near_mine = 2'($countones(occ & near_sel));
    far_mine  = 3'($countones(occ & far_sel));
    cnt_out.near_cnt = cnt_in.near_cnt + 4'(near_mine);
    cnt_out.far_cnt  = cnt_in.far_cnt + 5'(far_mine);
  end

  assign col_q = col_r;

endmodule

/* hw/rtl/cagp_out_fifo.sv */
// cagp_out_fifo: small result queue with slot reservation at input accept,
// so words in flight through the window pipeline always find room
// depends on cagp_pkg
module cagp_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                reserve,
  input  logic                wr_en,
  input  cagp_pkg::cagp_res_t wr_data,
  input  logic                rd_en,
  output cagp_pkg::cagp_res_t rd_data,
  output logic                not_empty,
  output logic                no_room
);
  import cagp_pkg::*;

  cagp_res_t               mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0]   count_r, count_nxt;
  logic [FIFO_CNT_W-1:0]   resv_r, resv_nxt;

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + FIFO_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + FIFO_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + FIFO_CNT_W'(wr_en) - FIFO_CNT_W'(rd_en);
    resv_nxt   = resv_r + FIFO_CNT_W'(reserve) - FIFO_CNT_W'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      resv_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      resv_r   <= resv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data   = mem_r[rd_ptr_r];
  assign not_empty = count_r != '0;
  assign no_room   = resv_r >= FIFO_CNT_W'(FIFO_DEPTH);

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (count_r < FIFO_CNT_W'(FIFO_DEPTH)) || rd_en)
    else $error("result queue written while full");

  a_resv_covers: assert property (@(posedge clk) disable iff (!rst_n)
    resv_r >= count_r)
    else $error("queued words exceed reserved slots");

endmodule

/* hw/rtl/cave_automaton_generation_pass_unit.sv */
// Cave automaton generation pass: one cellular-automaton generation over a raster
// stream of 2-bit cell codes. Takes one word per clock when the result side keeps up;
// results leave two rows plus two cells behind the input, and flush words push out
// the frame tail. Words pass the line store and window stages into the result queue.
// The per-column line store is one memory with one read and one write port, read at
// accept and written back the next cycle. Results pass through a four-word queue whose
// slots are reserved at accept, so the input stalls only once four results are owed.
// The line store needs no clearing after reset. Depends on cagp_pkg, cagp_ram,
// cagp_cell and cagp_out_fifo.
module cave_automaton_generation_pass_unit #(
  parameter int MAX_WIDTH  = cagp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cagp_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [1:0]  in_cell_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_new_cell,
  output logic        out_last_of_frame,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cagp_pkg::*;

  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int OROW_W = $clog2(MAX_HEIGHT);
  localparam int IROW_W = OROW_W + 1;

  function automatic int clamp_size(int v, int hi);
    int r;
    r = v;
    if (v < MIN_SIZE) r = MIN_SIZE;
    else if (v > hi) r = hi;
    return r;
  endfunction

  // configuration
  logic [4:0]  near_r;
  logic [4:0]  far_r;
  logic [9:0]  gw_r;
  logic [10:0] gh_r;
  logic [WW-1:0] w_r;
  logic [HW-1:0] h_r;
  logic          cfg_wr;

  // raster positions
  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  logic [IROW_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [OROW_W-1:0] out_row_r, out_row_nxt;

  // accept side
  logic        in_acc, go, emit, past_end, col_wrap, ocol_wrap;
  logic        border, last;
  logic [1:0]  cell_eff;
  logic [WIN_COLS-1:0] col_ok, row_ok;
  logic        fwd_hit;
  logic        res_acc;

  // line store stage
  logic                 a_vld_r, a_emit_r, a_border_r, a_last_r, a_fwd_r;
  logic [1:0]           a_cell_r;
  logic [COL_W-1:0]     a_addr_r;
  logic [WIN_COLS-1:0]  a_colok_r, a_rowok_r;
  logic [LINE_BITS-1:0] a_fwd_data_r;
  logic [LINE_BITS-1:0] ram_q, line_q, line_wr;
  logic [COL_BITS-1:0]  col_new;

  // window stage
  logic                b_vld_r, b_border_r, b_last_r;
  logic [WIN_COLS-1:0] b_colok_r, b_rowok_r;
  logic [COL_BITS-1:0] win_col [WIN_COLS];
  cagp_cnt_t           cnt [WIN_COLS];
  cagp_cnt_t           cnt_end;
  cagp_res_t           res, res_q;
  logic                rule_wall;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r <= NEAR_CUTOFF_RST;
      far_r  <= FAR_CUTOFF_RST;
      gw_r   <= GRID_WIDTH_RST;
      gh_r   <= GRID_HEIGHT_RST;
      w_r    <= WW'(clamp_size(int'(GRID_WIDTH_RST), MAX_WIDTH));
      h_r    <= HW'(clamp_size(int'(GRID_HEIGHT_RST), MAX_HEIGHT));
    end else if (cfg_wr) begin
      case (cagp_reg_t'(paddr[3:2]))
        REG_NEAR_CUTOFF: near_r <= pwdata[4:0];
        REG_FAR_CUTOFF:  far_r  <= pwdata[4:0];
        REG_GRID_WIDTH: begin
          gw_r <= pwdata[9:0];
          w_r  <= WW'(clamp_size(int'(pwdata[9:0]), MAX_WIDTH));
        end
        REG_GRID_HEIGHT: begin
          gh_r <= pwdata[10:0];
          h_r  <= HW'(clamp_size(int'(pwdata[10:0]), MAX_HEIGHT));
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cagp_reg_t'(paddr[3:2]))
      REG_NEAR_CUTOFF: prdata = 32'(near_r);
      REG_FAR_CUTOFF:  prdata = 32'(far_r);
      REG_GRID_WIDTH:  prdata = 32'(gw_r);
      REG_GRID_HEIGHT: prdata = 32'(gh_r);
      default:         prdata = '0;
    endcase
  end

  // ---------------- accept and raster tracking ----------------
  assign in_acc = in_valid && !in_stall;

  always_comb begin
    // a flush at the top-left corner is an idle tick
    go = in_acc && !(in_mode == MODE_FLUSH && in_row_r == '0 && in_col_r == '0);
    past_end = 32'(in_row_r) >= 32'(h_r);
    cell_eff = (in_mode == MODE_FLUSH || past_end) ? CODE_GRAVEL : in_cell_code;
    emit = (in_row_r > IROW_W'(2)) || (in_row_r == IROW_W'(2) && in_col_r >= COL_W'(2));

    col_wrap  = 32'(in_col_r) + 32'd1 >= 32'(w_r);
    ocol_wrap = 32'(out_col_r) + 32'd1 >= 32'(w_r);

    border = out_row_r == '0 || out_col_r == '0 ||
             32'(out_row_r) >= 32'(h_r) - 32'd1 || 32'(out_col_r) >= 32'(w_r) - 32'd1;
    last   = 32'(out_col_r) >= 32'(w_r) - 32'd1 && 32'(out_row_r) >= 32'(h_r) - 32'd1;

    // which window columns/rows lie inside the grid; index 0 is the newest
    col_ok = '1;
    col_ok[0] = 32'(out_col_r) + 32'd2 < 32'(w_r);
    col_ok[WIN_COLS-1] = out_col_r >= COL_W'(2);
    row_ok = '1;
    row_ok[0] = 32'(out_row_r) + 32'd2 < 32'(h_r);
    row_ok[WIN_ROWS-1] = out_row_r >= OROW_W'(2);

    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (go) begin
      in_col_nxt = col_wrap ? '0 : in_col_r + COL_W'(1);
      if (col_wrap && in_row_r != '1) begin
        in_row_nxt = in_row_r + IROW_W'(1);
      end
      if (emit) begin
        out_col_nxt = ocol_wrap ? '0 : out_col_r + COL_W'(1);
        if (ocol_wrap && out_row_r != '1) begin
          out_row_nxt = out_row_r + OROW_W'(1);
        end
        if (last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end
      end
    end
  end

  // stage A writes the same column this accept reads: take its data directly
  assign fwd_hit = a_vld_r && (a_addr_r == in_col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      a_vld_r   <= 1'b0;
      a_emit_r  <= 1'b0;
      a_fwd_r   <= 1'b0;
      b_vld_r   <= 1'b0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      a_vld_r   <= go;
      a_emit_r  <= go && emit;
      a_fwd_r   <= go && fwd_hit;
      b_vld_r   <= a_vld_r && a_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    a_cell_r     <= cell_eff;
    a_addr_r     <= in_col_r;
    a_border_r   <= border;
    a_last_r     <= last;
    a_colok_r    <= col_ok;
    a_rowok_r    <= row_ok;
    a_fwd_data_r <= line_wr;
    b_border_r   <= a_border_r;
    b_last_r     <= a_last_r;
    b_colok_r    <= a_colok_r;
    b_rowok_r    <= a_rowok_r;
  end

  // ---------------- line store ----------------
  cagp_ram #(
    .WIDTH (LINE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (a_vld_r),
    .wr_addr (a_addr_r),
    .wr_data (line_wr),
    .rd_en   (go),
    .rd_addr (in_col_r),
    .rd_data (ram_q)
  );

  assign line_q  = a_fwd_r ? a_fwd_data_r : ram_q;
  assign col_new = {line_q, a_cell_r};
  assign line_wr = col_new[LINE_BITS-1:0];

  // ---------------- window cells ----------------
  for (genvar k = 0; k < WIN_COLS; k++) begin : g_cell
    cagp_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (a_vld_r),
      .col_in   ((k == 0) ? col_new : win_col[(k == 0) ? 0 : k-1]),
      .col_q    (win_col[k]),
      .col_ok   (b_colok_r[k]),
      .outer    (1'(k == 0 || k == WIN_COLS - 1)),
      .row_ok   (b_rowok_r),
      .cnt_in   ((k == WIN_COLS - 1) ? cagp_cnt_t'('0) : cnt[(k == WIN_COLS-1) ? k : k+1]),
      .cnt_out  (cnt[k])
    );
  end

  assign cnt_end = cnt[0];

  always_comb begin
    rule_wall = (5'(cnt_end.near_cnt) >= near_r) || (cnt_end.far_cnt <= far_r);
    // border cells keep the centre code of the window
    res.new_cell      = b_border_r ? win_col[2][5:4] : (rule_wall ? CODE_WALL : CODE_GRAVEL);
    res.last_of_frame = b_last_r;
  end

  // ---------------- result queue ----------------
  assign res_acc = out_valid && !out_stall;

  cagp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .reserve   (go && emit),
    .wr_en     (b_vld_r),
    .wr_data   (res),
    .rd_en     (res_acc),
    .rd_data   (res_q),
    .not_empty (out_valid),
    .no_room   (in_stall)
  );

  assign out_new_cell      = res_q.new_cell;
  assign out_last_of_frame = res_q.last_of_frame;

  a_win_follows_store: assert property (@(posedge clk) disable iff (!rst_n)
    b_vld_r |-> $past(a_vld_r && a_emit_r))
    else $error("window result without a line store word before it");

  a_fwd_needs_writer: assert property (@(posedge clk) disable iff (!rst_n)
    a_fwd_r |-> $past(a_vld_r))
    else $error("column forwarded with no write in flight");

endmodule
